[src/cmm_pkg.sv]
`timescale 1ns / 1ps

package cmm_pkg;

    localparam int VALUE_W = 64;
    localparam int ROWS_W  = 32;
    localparam int CNT_W   = 13;

    // Operation codes of an input word.
    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_MARK = 1'b1;

    localparam logic [ROWS_W-1:0] ROWS_MAX = '1;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] value;
        logic               last;
    } cmm_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] lowest;
        logic [VALUE_W-1:0] highest;
        logic [ROWS_W-1:0]  row_count;
        logic [CNT_W-1:0]   distinct_count;
        logic [CNT_W-1:0]   table_size_used;
    } cmm_result_t;

    typedef struct packed {
        logic [VALUE_W-1:0] lowest;
        logic [VALUE_W-1:0] highest;
        logic [ROWS_W-1:0]  row_count;
    } cmm_stats_t;

    // One queue word: a mark (with its offset from the minimum) or the end
    // of a scan pass (with the final range of the column).
    typedef struct packed {
        logic               mark;
        logic               last;
        logic [VALUE_W-1:0] diff;
        cmm_stats_t         stats;
    } cmm_entry_t;

    typedef struct packed {
        logic valid;
        logic mark;
        logic last;
    } cmm_ctl_t;

endpackage

[src/cmm_front.sv]
`timescale 1ns / 1ps

module cmm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  cmm_pkg::cmm_item_t  item,
    output logic                push,
    output cmm_pkg::cmm_entry_t entry
);

    logic [cmm_pkg::VALUE_W-1:0] min_reg, min_next;
    logic [cmm_pkg::VALUE_W-1:0] max_reg, max_next;
    logic [cmm_pkg::ROWS_W-1:0]  rows_reg, rows_next;
    logic                        first_reg, first_next;
    logic                        is_mark;
    cmm_pkg::cmm_stats_t         scan_stats;
    cmm_pkg::cmm_stats_t         cur_stats;

    always_comb
    begin
        is_mark = 1'b0;
        case (item.operation)
            cmm_pkg::OP_SCAN: is_mark = 1'b0;
            cmm_pkg::OP_MARK: is_mark = 1'b1;
        endcase

        cur_stats.lowest    = min_reg;
        cur_stats.highest   = max_reg;
        cur_stats.row_count = rows_reg;

        if (first_reg)
        begin
            scan_stats.lowest    = item.value;
            scan_stats.highest   = item.value;
            scan_stats.row_count = cmm_pkg::ROWS_W'(1);
        end
        else
        begin
            scan_stats.lowest    = (item.value < min_reg) ? item.value : min_reg;
            scan_stats.highest   = (item.value > max_reg) ? item.value : max_reg;
            scan_stats.row_count = (rows_reg == cmm_pkg::ROWS_MAX) ? rows_reg
                                                                  : rows_reg + 1'b1;
        end

        min_next   = min_reg;
        max_next   = max_reg;
        rows_next  = rows_reg;
        first_next = first_reg;
        if (accept)
        begin
            if (!is_mark)
            begin
                min_next   = scan_stats.lowest;
                max_next   = scan_stats.highest;
                rows_next  = scan_stats.row_count;
                first_next = 1'b0;
            end
            if (item.last)
                first_next = 1'b1;
        end

        // Only marks and the end of a scan pass concern the bitmap side.
        push        = accept && (is_mark || item.last);
        entry.mark  = is_mark;
        entry.last  = item.last;
        entry.diff  = item.value - min_reg;
        entry.stats = is_mark ? cur_stats : scan_stats;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            rows_reg  <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            rows_reg  <= rows_next;
            first_reg <= first_next;
        end
    end

endmodule

[src/cmm_queue.sv]
`timescale 1ns / 1ps

module cmm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cmm_pkg::cmm_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output cmm_pkg::cmm_entry_t head
);

    cmm_pkg::cmm_entry_t entry_reg [2];
    logic                head_reg, head_next;
    logic [1:0]          count_reg, count_next;
    logic                tail;

    always_comb
    begin
        full  = (count_reg == 2'd2);
        empty = (count_reg == 2'd0);
        head  = entry_reg[head_reg];
        tail  = head_reg ^ count_reg[0];

        head_next = pop ? ~head_reg : head_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[tail] <= push_entry;
    end

endmodule

[src/cmm_mod.sv]
`timescale 1ns / 1ps

module cmm_mod #(
    parameter int BITMAP_SIZE = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  cmm_pkg::cmm_entry_t               in_entry,
    output cmm_pkg::cmm_ctl_t                 out_ctl,
    output cmm_pkg::cmm_stats_t               out_stats,
    output logic [$clog2(BITMAP_SIZE+1)-1:0]  out_idx,
    output logic [$clog2(BITMAP_SIZE+1)-1:0]  out_size
);

    localparam int TW     = $clog2(BITMAP_SIZE + 1);
    localparam int STEP_W = 8;
    localparam int NST    = cmm_pkg::VALUE_W / STEP_W;
    localparam int VW     = cmm_pkg::VALUE_W;

    // Eight restoring remainder steps; the remainder stays below the divisor.
    function automatic logic [TW-1:0] rem_step(input logic [TW-1:0]     r_in,
                                               input logic [STEP_W-1:0] bits,
                                               input logic [TW-1:0]     d);
        logic [TW:0]   t;
        logic [TW-1:0] r;
        r = r_in;
        for (int i = STEP_W - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, d})
                t = t - {1'b0, d};
            r = t[TW-1:0];
        end
        return r;
    endfunction

    logic [TW-1:0]       ts_reg, ts_next;
    logic [VW-1:0]       span;
    logic [TW-1:0]       span_size;
    logic [TW-1:0]       in_d;
    logic                in_zero;

    cmm_pkg::cmm_ctl_t   ctl_reg   [NST];
    cmm_pkg::cmm_stats_t stats_reg [NST];
    logic [TW-1:0]       rem_reg   [NST];
    logic [VW-1:0]       div_reg   [NST];
    logic [TW-1:0]       d_reg     [NST];
    logic                zero_reg  [NST];

    always_comb
    begin
        span = in_entry.stats.highest - in_entry.stats.lowest + 1'b1;
        // A full 64-bit range wraps to zero and takes the whole bitmap.
        if (span == '0 || span >= VW'(BITMAP_SIZE))
            span_size = TW'(BITMAP_SIZE);
        else
            span_size = span[TW-1:0];

        ts_next = ts_reg;
        if (adv && in_valid && !in_entry.mark)
            ts_next = span_size;

        in_zero = (ts_reg == '0);
        in_d    = in_zero ? TW'(1) : ts_reg;

        out_ctl   = ctl_reg[NST-1];
        out_stats = stats_reg[NST-1];
        out_idx   = rem_reg[NST-1];
        out_size  = zero_reg[NST-1] ? '0 : d_reg[NST-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg <= '0;
            for (int k = 0; k < NST; k++)
                ctl_reg[k] <= '0;
        end
        else
        begin
            ts_reg <= ts_next;
            if (adv)
            begin
                ctl_reg[0].valid <= in_valid;
                ctl_reg[0].mark  <= in_entry.mark;
                ctl_reg[0].last  <= in_entry.last;
                for (int k = 1; k < NST; k++)
                    ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stats_reg[0] <= in_entry.stats;
            rem_reg[0]   <= rem_step('0, in_entry.diff[VW-1 -: STEP_W], in_d);
            div_reg[0]   <= in_entry.diff << STEP_W;
            d_reg[0]     <= in_d;
            zero_reg[0]  <= in_zero;
            for (int k = 1; k < NST; k++)
            begin
                stats_reg[k] <= stats_reg[k-1];
                rem_reg[k]   <= rem_step(rem_reg[k-1], div_reg[k-1][VW-1 -: STEP_W],
                                         d_reg[k-1]);
                div_reg[k]   <= div_reg[k-1] << STEP_W;
                d_reg[k]     <= d_reg[k-1];
                zero_reg[k]  <= zero_reg[k-1];
            end
        end
    end

    a_rem_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[NST-1].valid && ctl_reg[NST-1].mark |-> rem_reg[NST-1] < d_reg[NST-1])
        else $error("bitmap index not below table size");

endmodule

[src/cmm_mark.sv]
`timescale 1ns / 1ps

module cmm_mark #(
    parameter int BITMAP_SIZE = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cmm_pkg::cmm_ctl_t                in_ctl,
    input  cmm_pkg::cmm_stats_t              in_stats,
    input  logic [$clog2(BITMAP_SIZE+1)-1:0] in_idx,
    input  logic [$clog2(BITMAP_SIZE+1)-1:0] in_size,
    output logic                             adv,
    output logic                             init_busy,
    output logic                             result_valid,
    input  logic                             result_stall,
    output cmm_pkg::cmm_result_t             result
);

    localparam int AW = $clog2(BITMAP_SIZE);
    localparam int TW = $clog2(BITMAP_SIZE + 1);
    localparam int CW = cmm_pkg::CNT_W;

    // Two bitmap banks: marks go to the active one while the other is swept
    // clear, so a new column starts on a clean bank; a switch waits while a sweep still runs.
    logic                bank0_mem [BITMAP_SIZE];
    logic                bank1_mem [BITMAP_SIZE];
    logic                rd0_reg, rd1_reg;

    cmm_pkg::cmm_ctl_t   m_ctl_reg;
    cmm_pkg::cmm_stats_t m_stats_reg;
    logic [AW-1:0]       m_idx_reg;
    logic [TW-1:0]       m_size_reg;

    logic                active_reg, dirty_reg;
    logic                scrub_busy_reg, scrub_init_reg, scrub_bank_reg;
    logic [AW-1:0]       scrub_addr_reg;

    logic                fwd_valid_reg, fwd_bank_reg;
    logic [AW-1:0]       fwd_idx_reg;

    logic [TW-1:0]       cnt_reg;
    logic                res_valid_reg;
    cmm_pkg::cmm_result_t res_reg;

    logic                was_set, fwd_hit;
    logic                do_mark, do_clear, need_flip, load;
    logic                we_mark0, we_mark1, we_scrub0, we_scrub1;
    logic                scrub_done;
    logic [TW-1:0]       cnt_sum;
    logic [TW+CW-1:0]    cnt_ext, size_ext;

    always_comb
    begin
        // The read of the word right behind misses the write made on the
        // same edge, so that write is forwarded.
        fwd_hit   = fwd_valid_reg && (fwd_bank_reg == active_reg) && (fwd_idx_reg == m_idx_reg);
        was_set   = (active_reg ? rd1_reg : rd0_reg) || fwd_hit;

        do_mark   = m_ctl_reg.valid && m_ctl_reg.mark;
        do_clear  = m_ctl_reg.valid && (!m_ctl_reg.mark || m_ctl_reg.last);
        need_flip = do_clear && (dirty_reg || do_mark);

        adv = !(res_valid_reg && result_stall) && !(need_flip && scrub_busy_reg);

        cnt_sum = cnt_reg + TW'(do_mark && !was_set);
        load    = adv && do_mark && m_ctl_reg.last;

        we_mark0  = adv && do_mark && !active_reg;
        we_mark1  = adv && do_mark && active_reg;
        we_scrub0 = scrub_busy_reg && (scrub_init_reg || !scrub_bank_reg);
        we_scrub1 = scrub_busy_reg && (scrub_init_reg || scrub_bank_reg);

        scrub_done = (scrub_addr_reg == AW'(BITMAP_SIZE - 1));

        cnt_ext  = {{CW{1'b0}}, cnt_sum};
        size_ext = {{CW{1'b0}}, m_size_reg};

        init_busy    = scrub_init_reg;
        result_valid = res_valid_reg;
        result       = res_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we_mark0)
            bank0_mem[m_idx_reg] <= 1'b1;
        else if (we_scrub0)
            bank0_mem[scrub_addr_reg] <= 1'b0;
        if (adv)
            rd0_reg <= bank0_mem[in_idx[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (we_mark1)
            bank1_mem[m_idx_reg] <= 1'b1;
        else if (we_scrub1)
            bank1_mem[scrub_addr_reg] <= 1'b0;
        if (adv)
            rd1_reg <= bank1_mem[in_idx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ctl_reg      <= '0;
            active_reg     <= 1'b0;
            dirty_reg      <= 1'b0;
            scrub_busy_reg <= 1'b1;
            scrub_init_reg <= 1'b1;
            scrub_bank_reg <= 1'b0;
            scrub_addr_reg <= '0;
            fwd_valid_reg  <= 1'b0;
            fwd_bank_reg   <= 1'b0;
            fwd_idx_reg    <= '0;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (scrub_busy_reg)
            begin
                scrub_addr_reg <= scrub_addr_reg + 1'b1;
                if (scrub_done)
                begin
                    scrub_busy_reg <= 1'b0;
                    scrub_init_reg <= 1'b0;
                end
            end

            if (adv)
            begin
                m_ctl_reg     <= in_ctl;
                fwd_valid_reg <= do_mark;
                fwd_bank_reg  <= active_reg;
                fwd_idx_reg   <= m_idx_reg;

                if (m_ctl_reg.valid)
                    cnt_reg <= do_clear ? '0 : cnt_sum;

                if (need_flip)
                begin
                    active_reg     <= ~active_reg;
                    dirty_reg      <= 1'b0;
                    scrub_busy_reg <= 1'b1;
                    scrub_bank_reg <= active_reg;
                    scrub_addr_reg <= '0;
                end
                else if (do_mark)
                    dirty_reg <= 1'b1;
            end

            if (load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_stats_reg <= in_stats;
            m_idx_reg   <= in_idx[AW-1:0];
            m_size_reg  <= in_size;
        end
        if (load)
        begin
            res_reg.lowest          <= m_stats_reg.lowest;
            res_reg.highest         <= m_stats_reg.highest;
            res_reg.row_count       <= m_stats_reg.row_count;
            res_reg.distinct_count  <= cnt_ext[CW-1:0];
            res_reg.table_size_used <= size_ext[CW-1:0];
        end
    end

    a_scrub_idle_bank: assert property (@(posedge clk) disable iff (!rst_n)
        scrub_busy_reg && !scrub_init_reg |-> scrub_bank_reg != active_reg)
        else $error("sweep runs on the bank that takes marks");

    a_no_work_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        scrub_init_reg |-> !m_ctl_reg.valid)
        else $error("word reached the bitmap before the first sweep ended");

    a_flip_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg != $past(active_reg) |-> $rose(scrub_busy_reg))
        else $error("bank switched while a sweep was still running");

endmodule

[src/column_min_max_distinct_count_unit.sv]
`timescale 1ns / 1ps

// Channel | Handshake                  | Word
// --------+----------------------------+------------------------------
// item    | item_valid / item_stall    | cmm_item_t: operation, value, last
// result  | result_valid / result_stall| cmm_result_t: one per mark pass
//
// One item per cycle while item_stall is low. A mark word goes through an
// eight-stage remainder pipeline and a bitmap read-modify-write; result_valid
// is registered when the final mark reaches the bitmap stage.
// After reset item_stall stays high while both bitmap banks are swept clear.
// An end of pass that follows a marked pass while the sweep started by the
// previous bank switch still runs waits for that sweep of the idle bank.
// A result held by result_stall freezes the back end; the two-word queue then
// fills and item_stall rises.

module column_min_max_distinct_count_unit #(
    parameter int BITMAP_SIZE = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  cmm_pkg::cmm_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output cmm_pkg::cmm_result_t result
);

    localparam int TW = $clog2(BITMAP_SIZE + 1);

    logic                accept;
    logic                push;
    cmm_pkg::cmm_entry_t push_entry;
    logic                q_full, q_empty;
    cmm_pkg::cmm_entry_t q_head;
    logic                adv;
    logic                init_busy;
    cmm_pkg::cmm_ctl_t   mod_ctl;
    cmm_pkg::cmm_stats_t mod_stats;
    logic [TW-1:0]       mod_idx;
    logic [TW-1:0]       mod_size;

    assign item_stall = init_busy || q_full;
    assign accept     = item_valid && !item_stall;

    cmm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .entry  (push_entry)
    );

    cmm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (adv && !q_empty),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    cmm_mod #(
        .BITMAP_SIZE (BITMAP_SIZE)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (!q_empty),
        .in_entry  (q_head),
        .out_ctl   (mod_ctl),
        .out_stats (mod_stats),
        .out_idx   (mod_idx),
        .out_size  (mod_size)
    );

    cmm_mark #(
        .BITMAP_SIZE (BITMAP_SIZE)
    ) u_mark (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctl       (mod_ctl),
        .in_stats     (mod_stats),
        .in_idx       (mod_idx),
        .in_size      (mod_size),
        .adv          (adv),
        .init_busy    (init_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int BITMAP_CELLS = 4096;
    localparam int ITEM_TARGET  = 1100;
    localparam int IDLE_LIMIT   = 40000;
    localparam int HOLD_CYCLES  = 6000;
    localparam int TAIL_CYCLES  = 100;
    localparam int REPORT_MAX   = 10;

    // Tracks the column statistics and the distinct-value bitmap, and keeps
    // the summaries that are still owed by the block.
    class column_stats_board;
        bit [cmm_pkg::VALUE_W-1:0] col_min;
        bit [cmm_pkg::VALUE_W-1:0] col_max;
        bit [cmm_pkg::ROWS_W-1:0]  rows;
        bit [cmm_pkg::CNT_W-1:0]   distinct;
        bit [cmm_pkg::CNT_W-1:0]   cell_count;
        bit                        pass_start;
        bit                        seen_cells[BITMAP_CELLS];
        cmm_pkg::cmm_result_t      owed_summaries[$];
        int                        errors;
        int                        reported;

        function new();
            col_min    = '0;
            col_max    = '0;
            rows       = '0;
            cell_count = '0;
            pass_start = 1'b1;
            errors     = 0;
            reported   = 0;
            clear_marks();
        endfunction

        function void clear_marks();
            foreach (seen_cells[i])
                seen_cells[i] = 1'b0;
            distinct = '0;
        endfunction

        function void note_item(cmm_pkg::cmm_item_t w);
            bit [cmm_pkg::VALUE_W-1:0] span;
            bit [cmm_pkg::VALUE_W-1:0] cells;
            bit [cmm_pkg::VALUE_W-1:0] idx;
            cmm_pkg::cmm_result_t      summary;
            if (w.operation == cmm_pkg::OP_SCAN)
            begin
                if (pass_start)
                begin
                    col_min    = w.value;
                    col_max    = w.value;
                    rows       = cmm_pkg::ROWS_W'(1);
                    pass_start = 1'b0;
                end
                else
                begin
                    if (w.value < col_min)
                        col_min = w.value;
                    if (w.value > col_max)
                        col_max = w.value;
                    if (rows != cmm_pkg::ROWS_MAX)
                        rows = rows + 1'b1;
                end
                if (w.last)
                begin
                    // A full 64-bit range wraps the span to zero.
                    span = col_max - col_min + 1'b1;
                    if (span == '0 || span >= cmm_pkg::VALUE_W'(BITMAP_CELLS))
                        cell_count = cmm_pkg::CNT_W'(BITMAP_CELLS);
                    else
                        cell_count = span[cmm_pkg::CNT_W-1:0];
                    clear_marks();
                    pass_start = 1'b1;
                end
            end
            else
            begin
                // Before any scan the table size is zero; it acts as one cell.
                cells = (cell_count == '0) ? cmm_pkg::VALUE_W'(1)
                                           : cmm_pkg::VALUE_W'(cell_count);
                idx = (w.value - col_min) % cells;
                if (!seen_cells[idx])
                begin
                    seen_cells[idx] = 1'b1;
                    distinct = distinct + 1'b1;
                end
                if (w.last)
                begin
                    summary.lowest          = col_min;
                    summary.highest         = col_max;
                    summary.row_count       = rows;
                    summary.distinct_count  = distinct;
                    summary.table_size_used = cell_count;
                    owed_summaries.push_back(summary);
                    clear_marks();
                    pass_start = 1'b1;
                end
            end
        endfunction

        function void field_ok(string name, bit [63:0] want, bit [63:0] got);
            if (want !== got)
            begin
                errors++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("mismatch in %s: expected %h, got %h", name, want, got);
                end
            end
        endfunction

        function void check_result(cmm_pkg::cmm_result_t got);
            cmm_pkg::cmm_result_t want;
            if (owed_summaries.size() == 0)
            begin
                errors++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("unexpected result word %h", got);
                end
                return;
            end
            want = owed_summaries.pop_front();
            field_ok("lowest", want.lowest, got.lowest);
            field_ok("highest", want.highest, got.highest);
            field_ok("row_count", 64'(want.row_count), 64'(got.row_count));
            field_ok("distinct_count", 64'(want.distinct_count), 64'(got.distinct_count));
            field_ok("table_size_used", 64'(want.table_size_used),
                     64'(got.table_size_used));
        endfunction

        function int outstanding();
            return owed_summaries.size();
        endfunction

        function int failures();
            return errors + owed_summaries.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    cmm_pkg::cmm_item_t   item;
    logic                 result_valid;
    logic                 result_stall;
    cmm_pkg::cmm_result_t result;

    column_stats_board sb;
    int items_sent;
    bit tx_calm;
    bit hold_req;

    column_min_max_distinct_count_unit #(
        .BITMAP_SIZE(BITMAP_CELLS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic bit [cmm_pkg::VALUE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(input logic op, input logic [cmm_pkg::VALUE_W-1:0] v,
                             input logic lst);
        cmm_pkg::cmm_item_t w;
        int                 gap;
        w.operation = op;
        w.value     = v;
        w.last      = lst;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(w);
        items_sent++;
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Picks a value for a column whose values lie in base .. base+span-1,
    // or anywhere when span is zero; mode 4 picks zero, all ones or a random value.
    function automatic bit [cmm_pkg::VALUE_W-1:0] column_value(
        bit [cmm_pkg::VALUE_W-1:0] base, bit [cmm_pkg::VALUE_W-1:0] span, int mode);
        int r;
        if (mode == 4)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                return '0;
            if (r == 1)
                return '1;
            return rand64();
        end
        if (span == '0)
            return rand64();
        return base + cmm_pkg::VALUE_W'($urandom_range(0, span[31:0] - 1));
    endfunction

    task automatic send_column();
        bit [cmm_pkg::VALUE_W-1:0] base;
        bit [cmm_pkg::VALUE_W-1:0] span;
        bit [cmm_pkg::VALUE_W-1:0] v;
        int mode;
        int n_scan;
        int n_mark;
        int passes;
        tx_calm = ($urandom_range(0, 5) == 0);
        mode = $urandom_range(0, 4);
        base = rand64();
        case (mode)
            0: span = cmm_pkg::VALUE_W'($urandom_range(1, 64));
            1: span = cmm_pkg::VALUE_W'($urandom_range(4090, 4100));
            2: span = cmm_pkg::VALUE_W'($urandom_range(1, 5000));
            default: span = '0;
        endcase
        n_scan = $urandom_range(1, 12);
        n_mark = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
        // Now and then the mark pass reuses the previous column's table.
        if ($urandom_range(0, 9) != 0)
        begin
            for (int k = 0; k < n_scan; k++)
            begin
                v = column_value(base, span, mode);
                // Pin both ends so that the range comes out exactly as chosen.
                if (span != '0 && mode < 3 && n_scan > 1)
                begin
                    if (k == 0)
                        v = base;
                    else if (k == n_scan - 1)
                        v = base + span - 1'b1;
                end
                send_word(cmm_pkg::OP_SCAN, v, k == n_scan - 1);
            end
        end
        passes = ($urandom_range(0, 5) == 0) ? 2 : 1;
        repeat (passes)
        begin
            for (int k = 0; k < n_mark; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    v = column_value(base, span + 3'd4, mode);
                else
                    v = rand64();
                send_word(cmm_pkg::OP_MARK, v, k == n_mark - 1);
            end
        end
    endtask

    initial
    begin
        bit paused;
        sb = new();
        items_sent = 0;
        tx_calm    = 1'b0;
        hold_req   = 1'b0;
        paused     = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Mark pass before any scan: the table acts as a single cell.
        send_word(cmm_pkg::OP_MARK, 64'd5, 1'b0);
        send_word(cmm_pkg::OP_MARK, '1, 1'b1);
        // Full 64-bit range: the span wraps to zero.
        send_word(cmm_pkg::OP_SCAN, '0, 1'b0);
        send_word(cmm_pkg::OP_SCAN, '1, 1'b1);
        send_word(cmm_pkg::OP_MARK, '1, 1'b0);
        send_word(cmm_pkg::OP_MARK, '0, 1'b0);
        send_word(cmm_pkg::OP_MARK, 64'h8000_0000_0000_0fff, 1'b0);
        send_word(cmm_pkg::OP_MARK, 64'h8000_0000_0000_0000, 1'b1);
        // One-value column, a mark outside the range, then a repeated mark pass.
        send_word(cmm_pkg::OP_SCAN, 64'd42, 1'b1);
        send_word(cmm_pkg::OP_MARK, 64'd42, 1'b0);
        send_word(cmm_pkg::OP_MARK, 64'd7, 1'b1);
        send_word(cmm_pkg::OP_MARK, 64'd9, 1'b1);
        // A range of exactly the bitmap size, with marks wrapping both ways.
        send_word(cmm_pkg::OP_SCAN, 64'd4195, 1'b0);
        send_word(cmm_pkg::OP_SCAN, 64'd100, 1'b0);
        send_word(cmm_pkg::OP_SCAN, 64'd3000, 1'b1);
        send_word(cmm_pkg::OP_MARK, 64'd100, 1'b0);
        send_word(cmm_pkg::OP_MARK, 64'd4196, 1'b0);
        send_word(cmm_pkg::OP_MARK, 64'd99, 1'b0);
        send_word(cmm_pkg::OP_MARK, 64'd4195, 1'b1);
        // Scan and mark words mixed within one column.
        send_word(cmm_pkg::OP_SCAN, 64'd10, 1'b0);
        send_word(cmm_pkg::OP_MARK, 64'd12, 1'b0);
        send_word(cmm_pkg::OP_SCAN, 64'd14, 1'b1);
        send_word(cmm_pkg::OP_MARK, 64'd14, 1'b1);
        drain_results();

        hold_req = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                tx_calm = 1'b0;
                repeat ($urandom_range(1, 4))
                    send_word(1'($urandom_range(0, 1)), rand64(),
                              $urandom_range(0, 3) == 0);
            end
            else
                send_column();
            if (!paused && items_sent >= ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int hold_left;
        int gap_left;
        int tick;
        bit rx_calm;
        hold_left = 0;
        gap_left  = 0;
        tick      = 0;
        rx_calm   = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                sb.check_result(result);
            tick++;
            if (tick % 256 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (hold_req)
            begin
                // Long hold so that the block backs up and stalls its input.
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                gap_left = rx_calm ? 0 : pick_gap();
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
src/cmm_pkg.sv
src/cmm_front.sv
src/cmm_queue.sv
src/cmm_mod.sv
src/cmm_mark.sv
src/column_min_max_distinct_count_unit.sv
sim/tb_top.sv
